>>> sv/mqll_pkg.sv
// Package for the multi-queue linked list engine.
// Holds widths, the "none" code, opcodes, request structs and the link normalizer.
// No dependencies.
`timescale 1ns / 1ps

package mqll_pkg;

    // Sizes
    localparam int THREADS = 64;
    localparam int QUEUES  = 65;

    // Link value width holds 0..THREADS, thread index width holds 0..THREADS-1
    localparam int TW  = $clog2(THREADS + 1);
    localparam int LAW = $clog2(THREADS);
    localparam int QAW = $clog2(QUEUES);

    // Fixed field widths of the stream payload
    localparam int OPCODE_W = 2;
    localparam int QID_W    = 7;
    localparam int TID_W    = 6;
    localparam int POP_W    = 7;

    localparam logic [TW-1:0] NONE = TW'(THREADS);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REM = 2'd2
    } op_t;

    // One queue table entry
    typedef struct packed {
        logic [TW-1:0] tail;
        logic [TW-1:0] head;
    } qent_t;

    localparam int QENT_W = $bits(qent_t);

    // Port requests to the link tables
    typedef struct packed {
        logic           we;
        logic [LAW-1:0] waddr;
        logic [TW-1:0]  wdata;
        logic           re;
        logic [LAW-1:0] raddr;
    } link_req_t;

    // Port requests to the queue table
    typedef struct packed {
        logic           we;
        logic [QAW-1:0] waddr;
        qent_t          wdata;
        logic           re;
        logic [QAW-1:0] raddr;
    } queue_req_t;

    // Any link value that is not a thread counts as none
    function automatic logic [TW-1:0] norm_tid(input logic [TW-1:0] v);
        return (v >= TW'(THREADS)) ? NONE : v;
    endfunction

endpackage

>>> sv/mqll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Per-entry valid bits (cleared by reset) tell the reader an entry was never written.
// Standalone; no package needed.
`timescale 1ns / 1ps

module mqll_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 7,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    output logic             rvalid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;

    // Storage array and read data; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Written-entry marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

>>> sv/mqll_ctrl.sv
// Operation sequencer: steps each legal enqueue, dequeue or remove through reads and
// write-backs of the queue and link tables, then holds the result in an output register.
// Depends on mqll_pkg.
`timescale 1ns / 1ps

module mqll_ctrl
    import mqll_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // operation input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] in_op,
    input  logic [QID_W-1:0]    in_q,
    input  logic [TID_W-1:0]    in_t,
    // table ports
    output queue_req_t          q_req,
    input  qent_t               q_rdata,
    input  logic                q_rvalid,
    output link_req_t           nxt_req,
    input  logic [TW-1:0]       nxt_rdata,
    input  logic                nxt_rvalid,
    output link_req_t           prv_req,
    input  logic [TW-1:0]       prv_rdata,
    input  logic                prv_rvalid,
    // result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POP_W-1:0]    out_popped,
    output logic                out_empty
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD1  = 5'b00010,
        S_RD2  = 5'b00100,
        S_WR2  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t         state_reg,  state_next;
    op_t            op_reg,     op_next;
    logic [QAW-1:0] q_reg,      q_next;
    logic [LAW-1:0] t_reg,      t_next;
    logic [TW-1:0]  head_reg,   head_next;
    logic [TW-1:0]  pend_pop_reg,   pend_pop_next;
    logic           pend_empty_reg, pend_empty_next;
    logic           out_valid_reg,  out_valid_next;
    logic [TW-1:0]  out_pop_reg,    out_pop_next;
    logic           out_empty_reg,  out_empty_next;

    logic           accept;
    logic           item_ok;
    logic [TW-1:0]  t_ext;
    logic [TW-1:0]  qh, qt, prv, nxt, rd_nxt;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign t_ext    = TW'(t_reg);

    // Unwritten entries read as none
    assign qh     = q_rvalid   ? norm_tid(q_rdata.head) : NONE;
    assign qt     = q_rvalid   ? norm_tid(q_rdata.tail) : NONE;
    assign prv    = prv_rvalid ? norm_tid(prv_rdata)    : NONE;
    assign nxt    = nxt_rvalid ? norm_tid(nxt_rdata)    : NONE;
    assign rd_nxt = nxt;

    // Legal operation on an existing queue and thread
    always_comb
    begin
        item_ok = 1'b0;
        if (in_q < QID_W'(QUEUES))
        begin
            case (in_op)
                OP_DEQ:  item_ok = 1'b1;
                OP_ENQ,
                OP_REM:  item_ok = ({1'b0, in_t} < (TID_W + 1)'(THREADS));
                default: item_ok = 1'b0;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        q_next          = q_reg;
        t_next          = t_reg;
        head_next       = head_reg;
        pend_pop_next   = pend_pop_reg;
        pend_empty_next = pend_empty_reg;
        out_valid_next  = out_valid_reg;
        out_pop_next    = out_pop_reg;
        out_empty_next  = out_empty_reg;
        q_req           = '0;
        nxt_req         = '0;
        prv_req         = '0;

        // result transfer leaves the output register empty
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(in_op);
                    q_next          = QAW'(in_q);
                    t_next          = LAW'(in_t);
                    pend_pop_next   = NONE;
                    pend_empty_next = 1'b0;
                    if (item_ok)
                    begin
                        q_req.re     = 1'b1;
                        q_req.raddr  = QAW'(in_q);
                        nxt_req.re   = 1'b1;
                        nxt_req.raddr = LAW'(in_t);
                        prv_req.re   = 1'b1;
                        prv_req.raddr = LAW'(in_t);
                        state_next   = S_RD1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_RD1:
            begin
                case (op_reg)
                    OP_ENQ:
                    begin
                        // link old tail forward, new thread back, move tail
                        if (qt != NONE)
                        begin
                            nxt_req.we    = 1'b1;
                            nxt_req.waddr = qt[LAW-1:0];
                            nxt_req.wdata = t_ext;
                        end
                        prv_req.we         = 1'b1;
                        prv_req.waddr      = t_reg;
                        prv_req.wdata      = qt;
                        q_req.we           = 1'b1;
                        q_req.waddr        = q_reg;
                        q_req.wdata.tail   = t_ext;
                        q_req.wdata.head   = (qt == NONE) ? t_ext : qh;
                        state_next         = S_WR2;
                    end
                    OP_DEQ:
                    begin
                        if (qh == NONE)
                        begin
                            pend_empty_next = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            head_next     = qh;
                            nxt_req.re    = 1'b1;
                            nxt_req.raddr = qh[LAW-1:0];
                            state_next    = S_RD2;
                        end
                    end
                    OP_REM:
                    begin
                        if (prv == NONE)
                        begin
                            q_req.we    = 1'b1;
                            q_req.waddr = q_reg;
                            if (nxt == NONE)
                            begin
                                q_req.wdata.tail = NONE;
                                q_req.wdata.head = NONE;
                            end
                            else
                            begin
                                prv_req.we       = 1'b1;
                                prv_req.waddr    = nxt[LAW-1:0];
                                prv_req.wdata    = NONE;
                                q_req.wdata.tail = qt;
                                q_req.wdata.head = nxt;
                            end
                        end
                        else if (nxt == NONE)
                        begin
                            nxt_req.we       = 1'b1;
                            nxt_req.waddr    = prv[LAW-1:0];
                            nxt_req.wdata    = NONE;
                            q_req.we         = 1'b1;
                            q_req.waddr      = q_reg;
                            q_req.wdata.tail = prv;
                            q_req.wdata.head = qh;
                        end
                        else
                        begin
                            // equal neighbors: only the back link is rewritten
                            if (prv != nxt)
                            begin
                                nxt_req.we    = 1'b1;
                                nxt_req.waddr = prv[LAW-1:0];
                                nxt_req.wdata = nxt;
                            end
                            prv_req.we    = 1'b1;
                            prv_req.waddr = nxt[LAW-1:0];
                            prv_req.wdata = prv;
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RD2:
            begin
                // dequeue: successor of the popped head becomes the head
                q_req.we    = 1'b1;
                q_req.waddr = q_reg;
                if (rd_nxt == NONE)
                begin
                    q_req.wdata.tail = NONE;
                    q_req.wdata.head = NONE;
                end
                else
                begin
                    prv_req.we       = 1'b1;
                    prv_req.waddr    = rd_nxt[LAW-1:0];
                    prv_req.wdata    = NONE;
                    q_req.wdata.tail = qt;
                    q_req.wdata.head = rd_nxt;
                end
                pend_pop_next = head_reg;
                state_next    = S_DONE;
            end

            S_WR2:
            begin
                // enqueue: new tail has no successor (written last on purpose)
                nxt_req.we    = 1'b1;
                nxt_req.waddr = t_reg;
                nxt_req.wdata = NONE;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pop_next   = pend_pop_reg;
                    out_empty_next = pend_empty_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        q_reg          <= q_next;
        t_reg          <= t_next;
        head_reg       <= head_next;
        pend_pop_reg   <= pend_pop_next;
        pend_empty_reg <= pend_empty_next;
        out_pop_reg    <= out_pop_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_popped = POP_W'(out_pop_reg);
    assign out_empty  = out_empty_reg;

endmodule

>>> sv/multi_queue_linked_list_engine_top.sv
// Top level of the multi-queue linked list engine.
// Instantiates mqll_ctrl and three mqll_ram tables; uses mqll_pkg.
//
// Usage:
//   Keeps QUEUES FIFO queues of thread ids as doubly linked lists.
//   Input channel (s_*): one transfer is one operation. s_tuser carries the
//   opcode (enqueue, dequeue, remove); s_tdata carries queue_id and thread_id.
//   Output channel (m_*): exactly one result transfer per operation, in order:
//   the popped thread (THREADS means none) and the empty flag.
//   Timing: every operation goes through the sequencer, which reads the queue
//   table and the link tables through one port each (registered reads) and
//   writes them back. Unused opcodes and queues skip the table steps; remove
//   and empty dequeue end after the first step; enqueue and non-empty dequeue
//   add a second step. The result is registered after the last table write.
//   s_tready is high only while the sequencer is idle.
//   Reset: all queues empty and all links none, at once, through per-entry
//   written marks; no clearing pass.
//   Stall: a result waiting in the output register does not block the next
//   accept; the following result waits in the sequencer until the output
//   register is free.
`timescale 1ns / 1ps

module multi_queue_linked_list_engine_top
    import mqll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] queue_id, [12:7] thread_id, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] popped_thread, [7] zero
    output logic [0:0]  m_tuser    // [0] queue_was_empty
);

    queue_req_t        q_req;
    qent_t             q_rdata;
    logic              q_rvalid;
    logic [QENT_W-1:0] q_rdata_raw;
    link_req_t         nxt_req;
    logic [TW-1:0]     nxt_rdata;
    logic              nxt_rvalid;
    link_req_t         prv_req;
    logic [TW-1:0]     prv_rdata;
    logic              prv_rvalid;
    logic [POP_W-1:0]  popped;
    logic              empty;

    assign q_rdata = qent_t'(q_rdata_raw);

    // Sequencer
    mqll_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[OPCODE_W-1:0]),
        .in_q       (s_tdata[QID_W-1:0]),
        .in_t       (s_tdata[QID_W +: TID_W]),
        .q_req      (q_req),
        .q_rdata    (q_rdata),
        .q_rvalid   (q_rvalid),
        .nxt_req    (nxt_req),
        .nxt_rdata  (nxt_rdata),
        .nxt_rvalid (nxt_rvalid),
        .prv_req    (prv_req),
        .prv_rdata  (prv_rdata),
        .prv_rvalid (prv_rvalid),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_popped (popped),
        .out_empty  (empty)
    );

    // Head and tail of every queue
    mqll_ram #(
        .DEPTH (QUEUES),
        .WIDTH (QENT_W)
    ) u_queue_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (q_req.we),
        .waddr  (q_req.waddr),
        .wdata  (q_req.wdata),
        .re     (q_req.re),
        .raddr  (q_req.raddr),
        .rdata  (q_rdata_raw),
        .rvalid (q_rvalid)
    );

    // Next links
    mqll_ram #(
        .DEPTH (THREADS),
        .WIDTH (TW)
    ) u_next_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (nxt_req.we),
        .waddr  (nxt_req.waddr),
        .wdata  (nxt_req.wdata),
        .re     (nxt_req.re),
        .raddr  (nxt_req.raddr),
        .rdata  (nxt_rdata),
        .rvalid (nxt_rvalid)
    );

    // Previous links
    mqll_ram #(
        .DEPTH (THREADS),
        .WIDTH (TW)
    ) u_prev_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (prv_req.we),
        .waddr  (prv_req.waddr),
        .wdata  (prv_req.wdata),
        .re     (prv_req.re),
        .raddr  (prv_req.raddr),
        .rdata  (prv_rdata),
        .rvalid (prv_rvalid)
    );

    assign m_tdata = {1'b0, popped};
    assign m_tuser = empty;

endmodule

>>> sv/mqll_checker.sv
// Port-level checker for the multi-queue linked list engine, bound to the top level.
// Depends on mqll_pkg and multi_queue_linked_list_engine_top.
`timescale 1ns / 1ps

module mqll_checker
    import mqll_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Empty flag only comes with a none result
    a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[POP_W-1:0] == NONE)
        else $error("empty flag with a thread id");

    // Popped value is a thread or none, padding zero
    a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7] && m_tdata[POP_W-1:0] <= NONE)
        else $error("popped value out of range");

    // One operation at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted back to back");

endmodule

bind multi_queue_linked_list_engine_top mqll_checker u_mqll_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/multi_queue_linked_list_engine_top_tb.sv
// Self-checking testbench for multi_queue_linked_list_engine_top.
// Drives enqueue/dequeue/remove transfers, predicts each result with a shadow
// copy of the queue and link tables; depends on mqll_pkg and the engine RTL.
`timescale 1ns / 1ps

module multi_queue_linked_list_engine_top_tb;
    import mqll_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOT_QUEUES = 4;
    localparam int NO_HOME = -1;

    typedef struct {
        logic [POP_W-1:0] thread;
        logic             was_empty;
    } pop_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    // Shadow tables of the engine
    logic [TW-1:0] shadow_head [QUEUES];
    logic [TW-1:0] shadow_tail [QUEUES];
    logic [TW-1:0] shadow_next [THREADS];
    logic [TW-1:0] shadow_prev [THREADS];

    // Queue each thread was last put in, for picking sensible operations
    int thread_home [THREADS];

    pop_result_t expected_pops [$];
    int          n_fail;
    bit          src_jitter;
    bit          sink_jitter;
    int          sink_hold;

    multi_queue_linked_list_engine_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("multi_queue_linked_list_engine_top_tb NOT OK");
        $finish;
    end

    // Link values past the last thread mean none
    function automatic logic [TW-1:0] as_link(input logic [TW-1:0] v);
        return (v < THREADS) ? v : NONE;
    endfunction

    function automatic void log_fail(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endfunction

    // Apply one operation to the shadow tables; returns the pop it produces
    function automatic pop_result_t apply_op(input logic [OPCODE_W-1:0] op,
                                             input logic [QID_W-1:0] q,
                                             input logic [TID_W-1:0] t);
        pop_result_t   r;
        logic [TW-1:0] hd;
        logic [TW-1:0] tl;
        logic [TW-1:0] nx;
        logic [TW-1:0] pv;
        r.thread    = NONE;
        r.was_empty = 1'b0;
        if (q < QUEUES) begin
            if (op == OP_DEQ) begin
                hd = as_link(shadow_head[q]);
                if (hd == NONE)
                    r.was_empty = 1'b1;
                else begin
                    nx = as_link(shadow_next[hd[LAW-1:0]]);
                    if (nx == NONE) begin
                        shadow_head[q] = NONE;
                        shadow_tail[q] = NONE;
                    end
                    else begin
                        shadow_prev[nx[LAW-1:0]] = NONE;
                        shadow_head[q] = nx;
                    end
                    r.thread = hd;
                end
            end
            else if (op == OP_ENQ) begin
                tl = as_link(shadow_tail[q]);
                if (tl == NONE) begin
                    shadow_prev[t] = NONE;
                    shadow_next[t] = NONE;
                    shadow_head[q] = TW'(t);
                end
                else begin
                    shadow_next[tl[LAW-1:0]] = TW'(t);
                    shadow_prev[t] = tl;
                    shadow_next[t] = NONE;
                end
                shadow_tail[q] = TW'(t);
            end
            else if (op == OP_REM) begin
                pv = as_link(shadow_prev[t]);
                nx = as_link(shadow_next[t]);
                if (pv == NONE) begin
                    if (nx == NONE) begin
                        shadow_head[q] = NONE;
                        shadow_tail[q] = NONE;
                    end
                    else begin
                        shadow_prev[nx[LAW-1:0]] = NONE;
                        shadow_head[q] = nx;
                    end
                end
                else if (nx == NONE) begin
                    shadow_next[pv[LAW-1:0]] = NONE;
                    shadow_tail[q] = pv;
                end
                else begin
                    // equal neighbors: next link of the neighbor is left alone
                    if (pv != nx)
                        shadow_next[pv[LAW-1:0]] = nx;
                    shadow_prev[nx[LAW-1:0]] = pv;
                end
            end
        end
        return r;
    endfunction

    // One operation transfer; called at a rising edge, returns at the accepting edge
    task automatic send_op(input logic [OPCODE_W-1:0] op,
                           input logic [QID_W-1:0] q,
                           input logic [TID_W-1:0] t);
        int          gap;
        pop_result_t r;
        gap = 0;
        while (src_jitter && $urandom_range(99) < 20)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, t, q};
        do @(posedge clk); while (!s_tready);
        r = apply_op(op, q, t);
        expected_pops.push_back(r);
        // track membership for the random picker
        if (q < QUEUES) begin
            if (op == OP_ENQ)
                thread_home[t] = int'(q);
            else if (op == OP_REM)
                thread_home[t] = NO_HOME;
            else if (op == OP_DEQ && r.thread != NONE)
                thread_home[r.thread[LAW-1:0]] = NO_HOME;
        end
    endtask

    function automatic logic [QID_W-1:0] pick_queue();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return QID_W'($urandom_range(HOT_QUEUES - 1));
        else if (roll < 70)
            return QID_W'(QUEUES - 1);
        return QID_W'($urandom_range(QUEUES - 1));
    endfunction

    // Mostly well-formed traffic on a few busy queues, with some noise
    task automatic send_random_op();
        int               pick;
        int               tries;
        bit               found;
        logic [TID_W-1:0] t;
        logic [QID_W-1:0] q;
        pick  = $urandom_range(99);
        found = 1'b0;
        t     = '0;
        if (pick >= 92) begin
            // noise: out-of-range queues, unused opcode, rare misuse
            if ($urandom_range(3) != 0)
                q = QID_W'($urandom_range(127, QUEUES));
            else
                q = QID_W'($urandom_range(127));
            send_op(OPCODE_W'($urandom_range(3)), q, TID_W'($urandom));
        end
        else if (pick < 42) begin
            for (tries = 0; tries < 16 && !found; tries++) begin
                t = TID_W'($urandom_range(THREADS - 1));
                found = (thread_home[t] == NO_HOME);
            end
            if (found)
                send_op(OP_ENQ, pick_queue(), t);
            else
                send_op(OP_DEQ, pick_queue(), TID_W'($urandom));
        end
        else if (pick < 70)
            send_op(OP_DEQ, pick_queue(), TID_W'($urandom));
        else begin
            for (tries = 0; tries < 16 && !found; tries++) begin
                t = TID_W'($urandom_range(THREADS - 1));
                found = (thread_home[t] != NO_HOME);
            end
            if (found)
                send_op(OP_REM, QID_W'(thread_home[t]), t);
            else
                send_op(OP_DEQ, pick_queue(), TID_W'($urandom));
        end
    endtask

    // Field extremes, every opcode and the corner cases of remove
    task automatic test_directed();
        send_op(OP_DEQ, 7'd0, 6'h2A);       // empty queue
        send_op(OP_ENQ, 7'd0, 6'd0);
        send_op(OP_ENQ, 7'd0, 6'd63);
        send_op(OP_ENQ, 7'd0, 6'd5);
        send_op(OP_DEQ, 7'd0, 6'h15);
        send_op(OP_ENQ, 7'd0, 6'd7);
        send_op(OP_REM, 7'd0, 6'd5);        // middle of list
        send_op(OP_DEQ, 7'd0, 6'd0);
        send_op(OP_DEQ, 7'd0, 6'd63);
        send_op(OP_DEQ, 7'd0, 6'd0);
        send_op(OP_ENQ, 7'd64, 6'd10);      // last queue
        send_op(OP_ENQ, 7'd64, 6'd11);
        send_op(OP_REM, 7'd64, 6'd11);      // tail
        send_op(OP_REM, 7'd64, 6'd10);      // only member
        send_op(OP_DEQ, 7'd64, 6'd63);
        send_op(OP_ENQ, 7'd1, 6'd20);
        send_op(OP_ENQ, 7'd1, 6'd21);
        send_op(OP_REM, 7'd1, 6'd20);       // head
        send_op(OP_DEQ, 7'd1, 6'd0);
        send_op(OP_UNUSED, 7'd0, 6'd0);
        send_op(OP_ENQ, 7'd65, 6'd1);       // queue out of range
        send_op(OP_DEQ, 7'd127, 6'd63);
        send_op(OP_REM, 7'd100, 6'd63);
        // re-enqueue makes thread 31 sit between two copies of thread 30
        send_op(OP_ENQ, 7'd2, 6'd30);
        send_op(OP_ENQ, 7'd2, 6'd31);
        send_op(OP_ENQ, 7'd2, 6'd30);
        send_op(OP_REM, 7'd2, 6'd31);       // previous equals next
        send_op(OP_DEQ, 7'd2, 6'd0);
        send_op(OP_DEQ, 7'd2, 6'd0);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_op();
    endtask

    // No idling on either side
    task automatic test_quiet_stretch(input int count);
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        repeat (count) send_random_op();
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
    endtask

    // Receiver holds off while transfers keep coming, so the engine backs up
    task automatic test_backpressure(input int count);
        sink_hold = 400;
        repeat (count) send_random_op();
    endtask

    // Result receiver and checker
    initial
    begin : result_sink
        pop_result_t want;
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                if (expected_pops.size() == 0)
                    log_fail($sformatf("result with none expected: thread %0d empty %0d",
                                       m_tdata[POP_W-1:0], m_tuser[0]));
                else begin
                    want = expected_pops.pop_front();
                    if (m_tdata[POP_W-1:0] !== want.thread)
                        log_fail($sformatf("popped_thread expected %0d got %0d",
                                           want.thread, m_tdata[POP_W-1:0]));
                    if (m_tuser[0] !== want.was_empty)
                        log_fail($sformatf("queue_was_empty expected %0d got %0d",
                                           want.was_empty, m_tuser[0]));
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(sink_jitter && $urandom_range(99) < 20);
        end
    end

    // Main sequence
    initial
    begin : main_seq
        int i;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        n_fail      = 0;
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        sink_hold   = 0;
        for (i = 0; i < QUEUES; i++) begin
            shadow_head[i] = NONE;
            shadow_tail[i] = NONE;
        end
        for (i = 0; i < THREADS; i++) begin
            shadow_next[i] = NONE;
            shadow_prev[i] = NONE;
            thread_home[i] = NO_HOME;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(700);
        test_quiet_stretch(300);
        test_backpressure(40);
        test_random_traffic(560);

        // drain the remaining results
        s_tvalid <= 1'b0;
        while (expected_pops.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (n_fail == 0)
            $display("multi_queue_linked_list_engine_top_tb OK");
        else
            $display("multi_queue_linked_list_engine_top_tb NOT OK");
        $finish;
    end

endmodule
